// ----- rtl/tga_rle_scanline_decoder_macros.svh -----
// assertion macros for the targa rle scanline decoder
// expects signals clk and rst_n in the including scope
`ifndef TGA_RLE_SCANLINE_DECODER_MACROS_SVH
`define TGA_RLE_SCANLINE_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/trd_pkg.sv -----
// shared types, constants and helpers for the targa rle scanline decoder
// no dependencies
package trd_pkg;

  localparam int BYTE_W         = 8;
  localparam int WIDTH_W        = 13;
  localparam int COUNT_W        = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int MAX_LINE_WIDTH = 4096;

  typedef enum logic [1:0] {
    FMT_8BIT  = 2'd0,
    FMT_16BIT = 2'd1,
    FMT_24BIT = 2'd2,
    FMT_32BIT = 2'd3
  } trd_fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT      = 2'd0,
    REG_TOP_BIT_ALPHA     = 2'd1,
    REG_RUN_LENGTH_PACKED = 2'd2,
    REG_LINE_WIDTH        = 2'd3
  } trd_reg_t;

  typedef struct packed {
    trd_fmt_t             pixel_format;
    logic                 top_bit_alpha;
    logic                 run_length_packed;
    logic [WIDTH_W-1:0]   line_width;
  } trd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  alpha;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [COUNT_W-1:0] repeat_count;
    logic               line_end;
  } trd_pix_t;

  // floor(c * 255 / 31) = 8c + floor(7c / 31), the second term by thresholds
  function automatic logic [BYTE_W-1:0] widen5(input logic [4:0] c);
    logic [2:0] frac;
    frac = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
         + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
    return {c, 3'b000} + {5'b00000, frac};
  endfunction

endpackage

// ----- rtl/trd_ifs.sv -----
// channel interfaces: stream byte in, decoded pixel run out, register writes
// depends on trd_pkg
interface trd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [trd_pkg::BYTE_W-1:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface trd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [trd_pkg::BYTE_W-1:0]  alpha;
  logic [trd_pkg::BYTE_W-1:0]  red;
  logic [trd_pkg::BYTE_W-1:0]  green;
  logic [trd_pkg::BYTE_W-1:0]  blue;
  logic [trd_pkg::COUNT_W-1:0] repeat_count;
  logic                        line_end;
  modport source (output valid, output alpha, output red, output green, output blue,
                  output repeat_count, output line_end, input ready);
  modport sink   (input valid, input alpha, input red, input green, input blue,
                  input repeat_count, input line_end, output ready);
endinterface

interface trd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trd_pkg::CFG_IDX_W-1:0]  index;
  logic [trd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tga_rle_scanline_decoder.sv -----
// targa rle scanline decoder: byte stream in, widened pixel runs out, one byte per cycle
// while the output is not stalled. Each accepted byte goes to an input register; once the
// output register has room, a single pass of decode logic updates the packet state and,
// when the byte completes a pixel, loads the output register. Throughput is one byte per
// cycle while out_pix is not stalled; a pixel of n source bytes gives one run per n bytes
// (plus one byte per packet header). in_byte.ready falls only when the input register is
// full and the output register holds an untaken run. Register writes are taken every cycle
// and should be made with the decoder idle. A run is clipped to the pixels left in the
// scanline, and line_end marks the run that completes it.
// depends on trd_pkg, trd_ifs, trd_cfg_regs, trd_decode and the assertion macro header
module tga_rle_scanline_decoder (
  input  logic     clk,
  input  logic     rst_n,
  trd_byte_if.sink in_byte,
  trd_pix_if.source out_pix,
  trd_cfg_if.sink  cfg_wr
);
  import trd_pkg::*;

  `include "tga_rle_scanline_decoder_macros.svh"

  trd_cfg_t cfg;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;

  // output register
  logic     out_valid_r, out_valid_nxt;
  trd_pix_t out_pix_r;

  logic     in_fire;
  logic     out_free;
  logic     advance;
  logic     has_result;
  trd_pix_t pix;

  trd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  trd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .byte_i     (s1_byte_r),
    .cfg        (cfg),
    .has_result (has_result),
    .pix        (pix)
  );

  // the output register can take a run this cycle
  assign out_free = !out_valid_r || out_pix.ready;
  // the held byte is decoded now; a byte giving no run still waits for room
  assign advance  = s1_valid_r && out_free;
  assign in_byte.ready = !s1_valid_r || out_free;
  assign in_fire  = in_byte.valid && in_byte.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_free ? (advance && has_result) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte.stream_byte;
    end
    if (advance && has_result) begin
      out_pix_r <= pix;
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.alpha        = out_pix_r.alpha;
  assign out_pix.red          = out_pix_r.red;
  assign out_pix.green        = out_pix_r.green;
  assign out_pix.blue         = out_pix_r.blue;
  assign out_pix.repeat_count = out_pix_r.repeat_count;
  assign out_pix.line_end     = out_pix_r.line_end;

  // a run always covers one to 128 pixels
  `TRD_ASSERT_NOW(a_count_range, out_valid_r, (out_pix_r.repeat_count != '0) && (out_pix_r.repeat_count <= COUNT_W'(128)), "repeat count out of range")
  // a held byte is not lost or overwritten while the output side stalls
  `TRD_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_free, s1_valid_r && $stable(s1_byte_r), "held stream byte lost during stall")
  // a stalled run is neither dropped nor altered
  `TRD_ASSERT_NEXT(a_out_hold, out_valid_r && !out_pix.ready, out_valid_r && $stable(out_pix_r), "stalled run changed")

endmodule

// ----- rtl/trd_cfg_regs.sv -----
// configuration register bank, always ready to take a write
// depends on trd_pkg and trd_cfg_if
module trd_cfg_regs (
  input  logic         clk,
  input  logic         rst_n,
  trd_cfg_if.sink      cfg_wr,
  output trd_pkg::trd_cfg_t cfg
);
  import trd_pkg::*;

  trd_cfg_t cfg_r;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format      <= FMT_32BIT;
      cfg_r.top_bit_alpha     <= 1'b0;
      cfg_r.run_length_packed <= 1'b1;
      cfg_r.line_width        <= WIDTH_W'(1);
    end else if (cfg_wr.valid) begin
      case (trd_reg_t'(cfg_wr.index))
        REG_PIXEL_FORMAT:      cfg_r.pixel_format      <= trd_fmt_t'(cfg_wr.data[1:0]);
        REG_TOP_BIT_ALPHA:     cfg_r.top_bit_alpha     <= cfg_wr.data[0];
        REG_RUN_LENGTH_PACKED: cfg_r.run_length_packed <= cfg_wr.data[0];
        REG_LINE_WIDTH:        cfg_r.line_width        <= cfg_wr.data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/trd_decode.sv -----
// packet/pixel decode state and the single-pass pixel and run logic
// depends on trd_pkg
module trd_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [trd_pkg::BYTE_W-1:0] byte_i,
  input  trd_pkg::trd_cfg_t          cfg,
  output logic                      has_result,
  output trd_pkg::trd_pix_t          pix
);
  import trd_pkg::*;

  logic               expect_header_r, expect_header_nxt;
  logic               run_packet_r, run_packet_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [23:0]        bytes_r, bytes_nxt;
  logic [WIDTH_W-1:0] pos_r, pos_nxt;

  logic               header;
  logic               complete;
  logic [2:0]         nbytes;
  logic [31:0]        assembled;
  logic [BYTE_W-1:0]  lo, hi;
  logic [WIDTH_W-1:0] width_eff, remaining, raw13;
  logic [COUNT_W-1:0] raw_count, count;
  logic               line_end;

  assign header    = cfg.run_length_packed && expect_header_r;
  assign nbytes    = {1'b0, cfg.pixel_format} + 3'd1;
  assign complete  = ({1'b0, bip_r} + 3'd1) >= nbytes;
  assign assembled = {8'h00, bytes_r} | ({24'h000000, byte_i} << {bip_r, 3'b000});
  assign lo        = assembled[7:0];
  assign hi        = assembled[15:8];

  // channel widening per source format, run fields alongside
  always_comb begin
    pix.alpha        = '0;
    pix.red          = '0;
    pix.green        = '0;
    pix.blue         = lo;
    pix.repeat_count = count;
    pix.line_end     = line_end;
    case (cfg.pixel_format)
      FMT_8BIT: begin
        pix.blue = lo;
      end
      FMT_16BIT: begin
        pix.alpha = cfg.top_bit_alpha ? {BYTE_W{hi[7]}} : 8'hFF;
        pix.red   = widen5(hi[6:2]);
        pix.green = widen5({hi[1:0], lo[7:5]});
        pix.blue  = widen5(lo[4:0]);
      end
      FMT_24BIT: begin
        pix.alpha = 8'hFF;
        pix.red   = assembled[23:16];
        pix.green = hi;
      end
      FMT_32BIT: begin
        pix.alpha = assembled[31:24];
        pix.red   = assembled[23:16];
        pix.green = hi;
      end
      default: ;
    endcase
  end

  // run length, clipped to what is left of the line
  always_comb begin
    if (cfg.line_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (cfg.line_width > WIDTH_W'(MAX_LINE_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_LINE_WIDTH);
    end else begin
      width_eff = cfg.line_width;
    end
    remaining = (pos_r < width_eff) ? (width_eff - pos_r) : WIDTH_W'(1);
    if (cfg.run_length_packed && run_packet_r) begin
      raw_count = (left_r == '0) ? COUNT_W'(1) : left_r;
    end else begin
      raw_count = COUNT_W'(1);
    end
    raw13    = {{(WIDTH_W-COUNT_W){1'b0}}, raw_count};
    line_end = raw13 >= remaining;
    count    = (raw13 > remaining) ? remaining[COUNT_W-1:0] : raw_count;
  end

  assign has_result = !header && complete;

  always_comb begin
    expect_header_nxt = expect_header_r;
    run_packet_nxt    = run_packet_r;
    left_nxt          = left_r;
    bip_nxt           = bip_r;
    bytes_nxt         = bytes_r;
    pos_nxt           = pos_r;
    if (header) begin
      run_packet_nxt    = byte_i[7];
      left_nxt          = {1'b0, byte_i[6:0]} + COUNT_W'(1);
      expect_header_nxt = 1'b0;
      bip_nxt           = '0;
      bytes_nxt         = '0;
    end else if (!complete) begin
      bip_nxt   = bip_r + 2'd1;
      bytes_nxt = assembled[23:0];
    end else begin
      bip_nxt   = '0;
      bytes_nxt = '0;
      pos_nxt   = line_end ? '0 : pos_r + {{(WIDTH_W-COUNT_W){1'b0}}, count};
      if (cfg.run_length_packed) begin
        if (run_packet_r || left_r <= COUNT_W'(1)) begin
          left_nxt          = '0;
          expect_header_nxt = 1'b1;
        end else begin
          left_nxt = left_r - COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      run_packet_r    <= 1'b0;
      left_r          <= '0;
      bip_r           <= '0;
      bytes_r         <= '0;
      pos_r           <= '0;
    end else if (step) begin
      expect_header_r <= expect_header_nxt;
      run_packet_r    <= run_packet_nxt;
      left_r          <= left_nxt;
      bip_r           <= bip_nxt;
      bytes_r         <= bytes_nxt;
      pos_r           <= pos_nxt;
    end
  end

endmodule
